FILE: hw/rtl/bpm_pkg.sv
// Shared types and constants for the battery protection monitor.
// Item structs, configuration and state groups, fault bit positions.
// No dependencies.
`default_nettype none

package bpm_pkg;

  localparam int NUM_CELLS_DEF = 16;
  localparam int CELL_W        = 16;  // width of the cell masks on the result item
  localparam int SAMPLE_W      = 24;
  localparam int FAULT_W       = 8;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 32;

  // fault register bit positions
  localparam int F_CELL_OVP = 0;
  localparam int F_CELL_UVP = 1;
  localparam int F_SHORT    = 2;
  localparam int F_CHG_OCP  = 3;
  localparam int F_DSG_OCP  = 4;
  localparam int F_CHG_OTP  = 5;
  localparam int F_DSG_OTP  = 6;
  localparam int F_CHG_UTP  = 7;

  typedef enum logic [1:0] {
    REQ_CELL    = 2'd0,
    REQ_CURRENT = 2'd1,
    REQ_TEMP    = 2'd2
  } req_type_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVP      = 3'd0,
    CFG_UVP      = 3'd1,
    CFG_SHORT    = 3'd2,
    CFG_CHG_OCP  = 3'd3,
    CFG_DSG_OCP  = 3'd4,
    CFG_CHG_HOT  = 3'd5,
    CFG_DSG_HOT  = 3'd6,
    CFG_CHG_COLD = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]                 req_type;
    logic [3:0]                 cell_index;
    logic signed [SAMPLE_W-1:0] sample_value;
  } in_item_t;

  typedef struct packed {
    logic [FAULT_W-1:0] fault_flags;
    logic               charge_off_req;
    logic               discharge_off_req;
    logic [CELL_W-1:0]  overvolt_cells;
    logic [CELL_W-1:0]  undervolt_cells;
  } out_item_t;

  typedef struct packed {
    logic [31:0]                ovp_thresholds;
    logic [31:0]                uvp_thresholds;
    logic signed [SAMPLE_W-1:0] short_limit_ma;
    logic signed [SAMPLE_W-1:0] chg_overcurrent_ma;
    logic signed [SAMPLE_W-1:0] dsg_overcurrent_ma;
    logic [31:0]                chg_hot_thresholds;
    logic [31:0]                dsg_hot_thresholds;
    logic [31:0]                chg_cold_thresholds;
  } bpm_cfg_t;

  typedef struct packed {
    logic [CELL_W-1:0]  ov_mask;
    logic [CELL_W-1:0]  uv_mask;
    logic [FAULT_W-1:0] faults;
  } bpm_state_t;

endpackage

`default_nettype wire

FILE: hw/rtl/battery_protection_monitor_core.sv
// Top level of the battery protection monitor: input register, evaluation,
// protection state and result register. Uses bpm_pkg, bpm_cfg_regs, bpm_eval.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in_     | in        | in_valid / in_stall | in_item   (in_item_t)
//   out_    | out       | out_valid/out_stall | out_item  (out_item_t)
//   cfg_    | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One item per cycle sustained while out_stall is low; an accepted item moves
// from the input register into the result register, which drives out_item.
// The state update and the compares sit between those two registers, so the
// next item in the input register always sees the state left by the one before.
// rst_n is synchronous: it clears masks, faults, configuration and both valids.
// A stalled output holds the result register; the input register then fills
// and in_stall rises. cfg_ready is always high.
`default_nettype none

module battery_protection_monitor_core
  import bpm_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF
)
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int MASK_W = (NUM_CELLS < CELL_W) ? NUM_CELLS : CELL_W;

  bpm_cfg_t   cfg;
  bpm_state_t cur_state, nxt_state;
  out_item_t  res;

  logic              s1_valid_r;
  in_item_t          s1_item_r;
  logic              out_valid_r;
  out_item_t         out_item_r;
  logic [MASK_W-1:0] ov_mask_r;
  logic [MASK_W-1:0] uv_mask_r;
  logic [FAULT_W-1:0] fault_r;

  logic out_adv;   // result register may load
  logic s1_adv;    // item in the input register moves on
  logic in_take;   // new item accepted

  // Configuration: always ready; written only while the block is idle, by the user; the block does not enforce it.
  assign cfg_ready = 1'b1;

  bpm_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Widen the stored masks to the item width; bits above the cell count read zero.
  always_comb begin
    cur_state.ov_mask             = '0;
    cur_state.uv_mask             = '0;
    cur_state.ov_mask[MASK_W-1:0] = ov_mask_r;
    cur_state.uv_mask[MASK_W-1:0] = uv_mask_r;
    cur_state.faults              = fault_r;
  end

  bpm_eval #(
    .NUM_CELLS (NUM_CELLS)
  ) u_eval (
    .item (s1_item_r),
    .cfg  (cfg),
    .cur  (cur_state),
    .nxt  (nxt_state),
    .res  (res)
  );

  // Handshake: the result register frees when empty or taken; the input
  // register frees when empty or when its item moves into the result register.
  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      ov_mask_r   <= '0;
      uv_mask_r   <= '0;
      fault_r     <= '0;
    end else begin
      // input register: load a new item, or drop the one that moved on
      if (in_take) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end
      // result register valid
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
      // advance the protection state with the item that is evaluated
      if (s1_adv) begin
        ov_mask_r <= nxt_state.ov_mask[MASK_W-1:0];
        uv_mask_r <= nxt_state.uv_mask[MASK_W-1:0];
        fault_r   <= nxt_state.faults;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_item;
    end
    if (s1_adv) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------

  // The cell fault flags always agree with the masks carried on the item.
  a_ovp_flag_matches_mask : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.fault_flags[F_CELL_OVP] == (|out_item_r.overvolt_cells)))
    else $error("cell ovp flag disagrees with over-voltage mask");

  a_uvp_flag_matches_mask : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_item_r.fault_flags[F_CELL_UVP] == (|out_item_r.undervolt_cells)))
    else $error("cell uvp flag disagrees with under-voltage mask");

  // Short circuit is sticky until reset.
  a_short_sticky : assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(fault_r[F_SHORT])) |-> fault_r[F_SHORT])
    else $error("short-circuit fault cleared without reset");

  // Stall the input only while an item waits in the input register.
  a_stall_needs_item : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled with no item held");

endmodule

`default_nettype wire

FILE: hw/rtl/bpm_cfg_regs.sv
// Configuration register file of the battery protection monitor.
// Depends on bpm_pkg for the register index codes and the bpm_cfg_t group.
`default_nettype none

module bpm_cfg_regs
  import bpm_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  wr_en,
  input  wire logic [CFG_IDX_W-1:0]  wr_index,
  input  wire logic [CFG_DATA_W-1:0] wr_data,
  output bpm_cfg_t                   cfg
);

  bpm_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_OVP:      cfg_r.ovp_thresholds      <= wr_data;
        CFG_UVP:      cfg_r.uvp_thresholds      <= wr_data;
        CFG_SHORT:    cfg_r.short_limit_ma      <= signed'(wr_data[SAMPLE_W-1:0]);
        CFG_CHG_OCP:  cfg_r.chg_overcurrent_ma  <= signed'(wr_data[SAMPLE_W-1:0]);
        CFG_DSG_OCP:  cfg_r.dsg_overcurrent_ma  <= signed'(wr_data[SAMPLE_W-1:0]);
        CFG_CHG_HOT:  cfg_r.chg_hot_thresholds  <= wr_data;
        CFG_DSG_HOT:  cfg_r.dsg_hot_thresholds  <= wr_data;
        CFG_CHG_COLD: cfg_r.chg_cold_thresholds <= wr_data;
        default:      cfg_r <= cfg_r;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

FILE: hw/rtl/bpm_eval.sv
// Single-pass evaluation of one measurement item against the thresholds.
// Produces the next protection state and the result item.
// Depends on bpm_pkg.
`default_nettype none

module bpm_eval
  import bpm_pkg::*;
#(
  parameter int NUM_CELLS = NUM_CELLS_DEF
)
(
  input  wire in_item_t   item,
  input  wire bpm_cfg_t   cfg,
  input  wire bpm_state_t cur,
  output bpm_state_t      nxt,
  output out_item_t       res
);

  localparam int MASK_W = (NUM_CELLS < CELL_W) ? NUM_CELLS : CELL_W;
  localparam logic [5:0] NUM_CELLS_V = 6'(NUM_CELLS);

  logic signed [SAMPLE_W:0]   s_ext;      // sample widened for compares with unsigned mV
  logic signed [SAMPLE_W-1:0] s;
  logic signed [SAMPLE_W:0]   ov_set_t, ov_rel_t, uv_set_t, uv_rel_t;
  logic signed [SAMPLE_W-1:0] chot_set_t, chot_rel_t, dhot_set_t, dhot_rel_t;
  logic signed [SAMPLE_W-1:0] cold_set_t, cold_rel_t;
  logic                       cell_ok;
  logic                       ov_set, ov_rel, uv_set, uv_rel;
  logic [CELL_W-1:0]          ov_m, uv_m;
  logic [FAULT_W-1:0]         f;
  logic                       chg_off, dsg_off;

  assign s     = item.sample_value;
  assign s_ext = {s[SAMPLE_W-1], s};

  assign ov_set_t = signed'({9'd0, cfg.ovp_thresholds[31:16]});
  assign ov_rel_t = signed'({9'd0, cfg.ovp_thresholds[15:0]});
  assign uv_set_t = signed'({9'd0, cfg.uvp_thresholds[31:16]});
  assign uv_rel_t = signed'({9'd0, cfg.uvp_thresholds[15:0]});

  assign chot_set_t = signed'({{8{cfg.chg_hot_thresholds[31]}}, cfg.chg_hot_thresholds[31:16]});
  assign chot_rel_t = signed'({{8{cfg.chg_hot_thresholds[15]}}, cfg.chg_hot_thresholds[15:0]});
  assign dhot_set_t = signed'({{8{cfg.dsg_hot_thresholds[31]}}, cfg.dsg_hot_thresholds[31:16]});
  assign dhot_rel_t = signed'({{8{cfg.dsg_hot_thresholds[15]}}, cfg.dsg_hot_thresholds[15:0]});
  assign cold_set_t =
    signed'({{8{cfg.chg_cold_thresholds[31]}}, cfg.chg_cold_thresholds[31:16]});
  assign cold_rel_t =
    signed'({{8{cfg.chg_cold_thresholds[15]}}, cfg.chg_cold_thresholds[15:0]});

  assign cell_ok = ({2'b00, item.cell_index} < NUM_CELLS_V);

  // set test wins over release when the bands overlap
  assign ov_set = (s_ext >= ov_set_t);
  assign ov_rel = (s_ext <= ov_rel_t);
  assign uv_set = (s_ext <= uv_set_t);
  assign uv_rel = (s_ext >= uv_rel_t);

  always_comb begin
    ov_m    = cur.ov_mask;
    uv_m    = cur.uv_mask;
    f       = cur.faults;
    chg_off = 1'b0;
    dsg_off = 1'b0;

    unique case (item.req_type)
      REQ_CELL: begin
        for (int i = 0; i < MASK_W; i++) begin
          if (cell_ok && (item.cell_index == 4'(i))) begin
            if (ov_set)      ov_m[i] = 1'b1;
            else if (ov_rel) ov_m[i] = 1'b0;
            if (uv_set)      uv_m[i] = 1'b1;
            else if (uv_rel) uv_m[i] = 1'b0;
          end
        end
        f[F_CELL_OVP] = |ov_m;
        f[F_CELL_UVP] = |uv_m;
        chg_off       = |ov_m;
        dsg_off       = |uv_m;
      end
      REQ_CURRENT: begin
        if (s <= cfg.short_limit_ma) begin
          f[F_SHORT] = 1'b1;
          chg_off    = 1'b1;
          dsg_off    = 1'b1;
        end else begin
          f[F_CHG_OCP] = (s >= cfg.chg_overcurrent_ma);
          f[F_DSG_OCP] = (s <= cfg.dsg_overcurrent_ma);
          chg_off      = f[F_CHG_OCP];
          dsg_off      = f[F_DSG_OCP];
        end
      end
      REQ_TEMP: begin
        if (s >= chot_set_t) begin
          f[F_CHG_OTP] = 1'b1;
          chg_off      = 1'b1;
        end else if (s <= chot_rel_t) begin
          f[F_CHG_OTP] = 1'b0;
        end
        if (s >= dhot_set_t) begin
          f[F_DSG_OTP] = 1'b1;
          dsg_off      = 1'b1;
        end else if (s <= dhot_rel_t) begin
          f[F_DSG_OTP] = 1'b0;
        end
        if (s <= cold_set_t) begin
          f[F_CHG_UTP] = 1'b1;
          chg_off      = 1'b1;
        end else if (s >= cold_rel_t) begin
          f[F_CHG_UTP] = 1'b0;
        end
      end
      default: begin
        // unused request code: state holds, no requests
      end
    endcase
  end

  assign nxt.ov_mask = ov_m;
  assign nxt.uv_mask = uv_m;
  assign nxt.faults  = f;

  assign res.fault_flags       = f;
  assign res.charge_off_req    = chg_off;
  assign res.discharge_off_req = dsg_off;
  assign res.overvolt_cells    = ov_m;
  assign res.undervolt_cells   = uv_m;

endmodule

`default_nettype wire

FILE: dv/tb_battery_protection_monitor_core.sv
`timescale 1ns / 100ps
// Testbench for battery_protection_monitor_core: directed and random measurement items.
// Each result is checked against a local predictor of masks, faults and disable requests.
// Depends on bpm_pkg and the core RTL only.

module tb_battery_protection_monitor_core;
  import bpm_pkg::*;

  localparam int CYCLE_LIMIT    = 200000;
  localparam int PHASE_ITEMS    = 150;
  localparam int RESULT_LATENCY = 2;
  localparam int MAX_REPORTS    = 100;
  // measurement type with no meaning; the block must leave its state alone
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_item   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_item;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_OVP;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // set to run both sides flat out, with no idle cycles and no stalls
  bit          steady_flow = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;

  // predictor copies of the threshold registers and the protection state
  bpm_cfg_t   thr  = '0;
  bpm_state_t prot = '0;
  out_item_t  expected_results [$];
  out_item_t  want;

  // threshold words to load at the next programming pass, by register index
  logic [CFG_DATA_W-1:0] next_thresholds [8];

  battery_protection_monitor_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Hard stop: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver back-pressure: stall at random, with a chance of roughly 15 in a hundred.
  always @(posedge clk) begin
    out_stall <= !steady_flow && ($urandom_range(99) < 15);
  end

  task automatic report_mismatch(string what);
    // keep the log readable, but count every mismatch
    if (mismatch_count < MAX_REPORTS)
      $display("[cycle %0d] mismatch: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Work out the result of one measurement item and advance the predicted state.
  function automatic out_item_t predict_protection(in_item_t it);
    out_item_t         res;
    int                s;
    logic [CELL_W-1:0] cell_bit;
    logic              chg_off;
    logic              dsg_off;
    s = it.sample_value;
    chg_off = 1'b0;
    dsg_off = 1'b0;
    case (it.req_type)
      REQ_CELL: begin
        // an index past the last cell moves no mask bit, yet the faults still follow the masks
        if (it.cell_index < NUM_CELLS_DEF) begin
          cell_bit = '0;
          cell_bit[it.cell_index] = 1'b1;
          // set test first: when set and release overlap, set wins
          if (s >= int'(thr.ovp_thresholds[31:16])) prot.ov_mask |= cell_bit;
          else if (s <= int'(thr.ovp_thresholds[15:0])) prot.ov_mask &= ~cell_bit;
          if (s <= int'(thr.uvp_thresholds[31:16])) prot.uv_mask |= cell_bit;
          else if (s >= int'(thr.uvp_thresholds[15:0])) prot.uv_mask &= ~cell_bit;
        end
        prot.faults[F_CELL_OVP] = |prot.ov_mask;
        prot.faults[F_CELL_UVP] = |prot.uv_mask;
        chg_off = |prot.ov_mask;
        dsg_off = |prot.uv_mask;
      end
      REQ_CURRENT: begin
        if (s <= int'(thr.short_limit_ma)) begin
          // short is sticky and freezes both overcurrent bits
          prot.faults[F_SHORT] = 1'b1;
          chg_off = 1'b1;
          dsg_off = 1'b1;
        end else begin
          prot.faults[F_CHG_OCP] = (s >= int'(thr.chg_overcurrent_ma));
          prot.faults[F_DSG_OCP] = (s <= int'(thr.dsg_overcurrent_ma));
          chg_off = prot.faults[F_CHG_OCP];
          dsg_off = prot.faults[F_DSG_OCP];
        end
      end
      REQ_TEMP: begin
        if (s >= int'($signed(thr.chg_hot_thresholds[31:16]))) begin
          prot.faults[F_CHG_OTP] = 1'b1;
          chg_off = 1'b1;
        end else if (s <= int'($signed(thr.chg_hot_thresholds[15:0]))) begin
          prot.faults[F_CHG_OTP] = 1'b0;
        end
        if (s >= int'($signed(thr.dsg_hot_thresholds[31:16]))) begin
          prot.faults[F_DSG_OTP] = 1'b1;
          dsg_off = 1'b1;
        end else if (s <= int'($signed(thr.dsg_hot_thresholds[15:0]))) begin
          prot.faults[F_DSG_OTP] = 1'b0;
        end
        // cold runs the other way round: set at or below, release at or above
        if (s <= int'($signed(thr.chg_cold_thresholds[31:16]))) begin
          prot.faults[F_CHG_UTP] = 1'b1;
          chg_off = 1'b1;
        end else if (s >= int'($signed(thr.chg_cold_thresholds[15:0]))) begin
          prot.faults[F_CHG_UTP] = 1'b0;
        end
      end
      default: ;  // unused type: state holds, both requests stay low
    endcase
    res.fault_flags       = prot.faults;
    res.charge_off_req    = chg_off;
    res.discharge_off_req = dsg_off;
    res.overvolt_cells    = prot.ov_mask;
    res.undervolt_cells   = prot.uv_mask;
    return res;
  endfunction

  // Follow both input handshakes: track register writes, predict each accepted item.
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_OVP:      thr.ovp_thresholds      = cfg_data;
        CFG_UVP:      thr.uvp_thresholds      = cfg_data;
        CFG_SHORT:    thr.short_limit_ma      = cfg_data[SAMPLE_W-1:0];
        CFG_CHG_OCP:  thr.chg_overcurrent_ma  = cfg_data[SAMPLE_W-1:0];
        CFG_DSG_OCP:  thr.dsg_overcurrent_ma  = cfg_data[SAMPLE_W-1:0];
        CFG_CHG_HOT:  thr.chg_hot_thresholds  = cfg_data;
        CFG_DSG_HOT:  thr.dsg_hot_thresholds  = cfg_data;
        CFG_CHG_COLD: thr.chg_cold_thresholds = cfg_data;
        default: ;
      endcase
    end
    if (rst_n && in_valid && !in_stall)
      expected_results.push_back(predict_protection(in_item));
  end

  // Compare each accepted result, field by field, with the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result item with no prediction waiting");
      end else begin
        want = expected_results.pop_front();
        if (out_item.fault_flags !== want.fault_flags)
          report_mismatch($sformatf("fault_flags got %02h want %02h",
                                    out_item.fault_flags, want.fault_flags));
        if (out_item.charge_off_req !== want.charge_off_req)
          report_mismatch($sformatf("charge_off_req got %b want %b",
                                    out_item.charge_off_req, want.charge_off_req));
        if (out_item.discharge_off_req !== want.discharge_off_req)
          report_mismatch($sformatf("discharge_off_req got %b want %b",
                                    out_item.discharge_off_req, want.discharge_off_req));
        if (out_item.overvolt_cells !== want.overvolt_cells)
          report_mismatch($sformatf("overvolt_cells got %04h want %04h",
                                    out_item.overvolt_cells, want.overvolt_cells));
        if (out_item.undervolt_cells !== want.undervolt_cells)
          report_mismatch($sformatf("undervolt_cells got %04h want %04h",
                                    out_item.undervolt_cells, want.undervolt_cells));
      end
    end
  end

  // Pack a set/release pair into one threshold word, set in the upper half.
  function automatic logic [CFG_DATA_W-1:0] pack_pair(int set_val, int rel_val);
    return {16'(set_val), 16'(rel_val)};
  endfunction

  // Offer one item and hold it until accepted; idle before it at random.
  task automatic send_item(logic [1:0] kind, logic [3:0] cell_sel, int value);
    in_item_t it;
    it.req_type     = kind;
    it.cell_index   = cell_sel;
    it.sample_value = 24'(value);
    while (!steady_flow && ($urandom_range(99) < 15)) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every predicted result has come out, plus the latency.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (RESULT_LATENCY + 2) @(posedge clk);
  endtask

  // Load all eight registers from next_thresholds, only once the block is idle.
  task automatic program_thresholds();
    cfg_idx_t idx;
    settle();
    idx = idx.first();
    repeat (idx.num()) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= next_thresholds[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      idx = idx.next();
    end
    cfg_valid <= 1'b0;
  endtask

  // Choose a sample near one of the thresholds or fixed marks for this type, or anywhere.
  function automatic int pick_sample(logic [1:0] kind);
    int marks [6];
    int spread;
    case (kind)
      REQ_CELL: begin
        marks[0] = thr.ovp_thresholds[31:16];
        marks[1] = thr.ovp_thresholds[15:0];
        marks[2] = thr.uvp_thresholds[31:16];
        marks[3] = thr.uvp_thresholds[15:0];
        marks[4] = 3700;
        marks[5] = 0;
      end
      REQ_CURRENT: begin
        marks[0] = thr.short_limit_ma;
        marks[1] = thr.chg_overcurrent_ma;
        marks[2] = thr.dsg_overcurrent_ma;
        marks[3] = thr.short_limit_ma;
        marks[4] = thr.chg_overcurrent_ma;
        marks[5] = 0;
      end
      default: begin
        marks[0] = $signed(thr.chg_hot_thresholds[31:16]);
        marks[1] = $signed(thr.chg_hot_thresholds[15:0]);
        marks[2] = $signed(thr.dsg_hot_thresholds[31:16]);
        marks[3] = $signed(thr.dsg_hot_thresholds[15:0]);
        marks[4] = $signed(thr.chg_cold_thresholds[31:16]);
        marks[5] = $signed(thr.chg_cold_thresholds[15:0]);
      end
    endcase
    if ($urandom_range(3) == 0) return int'($urandom);
    spread = ($urandom_range(1) == 0) ? 2 : 200;
    return marks[$urandom_range(5)] + int'($urandom_range(2 * spread)) - spread;
  endfunction

  task automatic test_cell_thresholds();
    next_thresholds = '{default: '0};
    next_thresholds[CFG_OVP] = pack_pair(4200, 4100);
    next_thresholds[CFG_UVP] = pack_pair(2800, 3000);
    program_thresholds();
    send_item(REQ_CELL, 4'd0, 4200);        // over-voltage set on the boundary
    send_item(REQ_CELL, 4'd0, 4150);        // inside the band: hold
    send_item(REQ_CELL, 4'd0, 4100);        // release on the boundary
    send_item(REQ_CELL, 4'd15, 2800);       // under-voltage set, top cell
    send_item(REQ_CELL, 4'd15, 3000);       // under-voltage release
    send_item(REQ_CELL, 4'd7, -8388608);    // negative voltage sits below every threshold
    send_item(REQ_CELL, 4'd3, 8388607);
    // set below release: the set compare must win inside the overlap
    next_thresholds[CFG_OVP] = pack_pair(4000, 4200);
    program_thresholds();
    send_item(REQ_CELL, 4'd9, 4100);
  endtask

  task automatic test_pack_current();
    next_thresholds = '{default: '0};
    next_thresholds[CFG_SHORT]   = {8'hA5, 24'(-50000)};  // upper byte must be ignored
    next_thresholds[CFG_CHG_OCP] = 32'(5000);
    next_thresholds[CFG_DSG_OCP] = 32'(-20000);
    program_thresholds();
    send_item(REQ_CURRENT, 4'd0, 4999);
    send_item(REQ_CURRENT, 4'd0, 5000);
    send_item(REQ_CURRENT, 4'd0, -20000);
    send_item(REQ_CURRENT, 4'd0, -19999);
    send_item(REQ_CURRENT, 4'd0, -50000);   // short: sticky, overcurrent bits frozen
    send_item(REQ_CURRENT, 4'd0, 0);
    send_item(REQ_CURRENT, 4'd5, 8388607);
    send_item(REQ_CURRENT, 4'd5, -8388608);
  endtask

  task automatic test_temperature();
    next_thresholds = '{default: '0};
    next_thresholds[CFG_CHG_HOT]  = pack_pair(450, 400);
    next_thresholds[CFG_DSG_HOT]  = pack_pair(600, 550);
    next_thresholds[CFG_CHG_COLD] = pack_pair(0, 50);
    program_thresholds();
    send_item(REQ_TEMP, 4'd0, 450);
    send_item(REQ_TEMP, 4'd0, 425);
    send_item(REQ_TEMP, 4'd0, 400);
    send_item(REQ_TEMP, 4'd0, 600);
    send_item(REQ_TEMP, 4'd0, 0);
    send_item(REQ_TEMP, 4'd0, 50);
    send_item(REQ_TEMP, 4'd0, -8388608);
    send_item(REQ_TEMP, 4'd0, 8388607);
  endtask

  task automatic test_unused_type();
    // flags and masks left by the earlier tests must carry through untouched
    send_item(REQ_UNUSED, 4'hF, 8388607);
    send_item(REQ_UNUSED, 4'h0, -1);
  endtask

  task automatic test_random_phases();
    int         roll;
    int         ov_set;
    int         uv_set;
    int         hot_set;
    int         cold_set;
    logic [1:0] kind;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: next_thresholds = '{default: '0};
        1: begin
          // everything at its top end
          next_thresholds = '{default: 32'h7FFF_7FFF};
          next_thresholds[CFG_OVP]     = '1;
          next_thresholds[CFG_UVP]     = '1;
          next_thresholds[CFG_SHORT]   = 32'h007F_FFFF;
          next_thresholds[CFG_CHG_OCP] = 32'h007F_FFFF;
          next_thresholds[CFG_DSG_OCP] = 32'h007F_FFFF;
        end
        2: begin
          // everything at its bottom end
          next_thresholds = '{default: 32'h8000_8000};
          next_thresholds[CFG_OVP]     = '0;
          next_thresholds[CFG_UVP]     = '0;
          next_thresholds[CFG_SHORT]   = 32'hFF80_0000;
          next_thresholds[CFG_CHG_OCP] = 32'hFF80_0000;
          next_thresholds[CFG_DSG_OCP] = 32'hFF80_0000;
        end
        3: foreach (next_thresholds[i]) next_thresholds[i] = $urandom;
        default: begin
          // plausible pack settings, with the odd overlapping pair
          ov_set = $urandom_range(4400, 3900);
          next_thresholds[CFG_OVP] = pack_pair(ov_set, ov_set - int'($urandom_range(250)));
          if ($urandom_range(3) == 0)
            next_thresholds[CFG_OVP] = pack_pair(ov_set - int'($urandom_range(250)), ov_set);
          uv_set = $urandom_range(3000, 2500);
          next_thresholds[CFG_UVP] = pack_pair(uv_set, uv_set + int'($urandom_range(250)));
          next_thresholds[CFG_SHORT]   = {8'($urandom), 24'(-int'($urandom_range(200000, 20000)))};
          next_thresholds[CFG_CHG_OCP] = {8'($urandom), 24'($urandom_range(30000, 1000))};
          next_thresholds[CFG_DSG_OCP] = {8'($urandom), 24'(-int'($urandom_range(15000, 1000)))};
          hot_set = $urandom_range(550, 400);
          next_thresholds[CFG_CHG_HOT] = pack_pair(hot_set, hot_set - int'($urandom_range(80)));
          hot_set = $urandom_range(700, 550);
          next_thresholds[CFG_DSG_HOT] = pack_pair(hot_set, hot_set - int'($urandom_range(80)));
          cold_set = int'($urandom_range(150)) - 100;
          next_thresholds[CFG_CHG_COLD] = pack_pair(cold_set, cold_set + int'($urandom_range(80)));
        end
      endcase
      program_thresholds();
      // one phase runs without any idling on either side
      steady_flow = (phase == 5);
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(99);
        if (roll < 35) kind = REQ_CELL;
        else if (roll < 65) kind = REQ_CURRENT;
        else if (roll < 95) kind = REQ_TEMP;
        else kind = REQ_UNUSED;
        send_item(kind, 4'($urandom), pick_sample(kind));
      end
      steady_flow = 1'b0;
    end
  endtask

  initial begin
    // hold reset at the start, then release it for good
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_cell_thresholds();
    test_pack_current();
    test_temperature();
    test_unused_type();
    test_random_phases();
    settle();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bpm_pkg.sv
hw/rtl/bpm_cfg_regs.sv
hw/rtl/bpm_eval.sv
hw/rtl/battery_protection_monitor_core.sv
dv/tb_battery_protection_monitor_core.sv
